// ----- rtl/ptdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptdc_pkg
// Shared widths, mode codes, register indexes and bundle types for the
// presence-triggered dispense controller.
// ----------------------------------------------------------------------------
package ptdc_pkg;

    localparam int PROX_W    = 12;
    localparam int WEIGHT_W  = 18;
    localparam int MODE_W    = 3;
    localparam int TICKS_W   = 4;
    localparam int COOL_W    = 8;
    localparam int VISITOR_W = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam int S_TDATA_W = 32;   // 30 field bits, padded to whole bytes
    localparam int M_TDATA_W = 24;

    // Controller modes
    localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DETECT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DISPENSE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COOL     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EMPTY    = 3'd4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PROX_THRESH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FOOD_THRESH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REFILL_THRESH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COOL_TICKS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_TICKS     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TICKS     = 3'd5;

    // Register reset values
    localparam logic [PROX_W-1:0]   RST_PROX_THRESH   = 12'd1200;
    localparam logic [WEIGHT_W-1:0] RST_FOOD_THRESH   = 18'd15000;
    localparam logic [WEIGHT_W-1:0] RST_REFILL_THRESH = 18'd100000;
    localparam logic [COOL_W-1:0]   RST_COOL_TICKS    = 8'd20;
    localparam logic [TICKS_W-1:0]  RST_MIN_TICKS     = 4'd3;
    localparam logic [TICKS_W-1:0]  RST_MAX_TICKS     = 4'd7;

    typedef struct packed {
        logic [PROX_W-1:0]   proximity_threshold;
        logic [WEIGHT_W-1:0] food_weight_threshold;
        logic [WEIGHT_W-1:0] refill_weight_threshold;
        logic [COOL_W-1:0]   cooldown_ticks;
        logic [TICKS_W-1:0]  min_dispense_ticks;
        logic [TICKS_W-1:0]  max_dispense_ticks;
    } cfg_t;

    typedef struct packed {
        logic [VISITOR_W-1:0] visitor_count;
        logic                 empty_flag;
        logic                 clear_averages;
        logic                 process_photo;
        logic                 take_photo;
        logic                 motor_run;
        logic [MODE_W-1:0]    mode_code;
    } result_t;

endpackage

// ----- rtl/presence_triggered_dispense_controller.sv -----
// ----------------------------------------------------------------------------
// presence_triggered_dispense_controller
// Five-mode visitor-triggered feeder controller, one tick per transaction.
// ----------------------------------------------------------------------------
// Path: an accepted input transaction passes the input register, then the
//   result register, before it shows on m_tvalid.
// Throughput: one tick per cycle while m_tready is high; the update is a
//   single pass of comparisons and counter increments between the registers.
// Reset: aresetn is synchronous, active low; it empties both stages, puts
//   the controller in waiting and loads every config register with its default.
// ----------------------------------------------------------------------------
module presence_triggered_dispense_controller (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [ptdc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ptdc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    // Tick input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptdc_pkg::S_TDATA_W-1:0]    s_tdata,  // proximity_level[11:0],
                                                         // tray_weight[29:12], zero pad

    // Result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptdc_pkg::M_TDATA_W-1:0]    m_tdata   // mode_code[2:0], motor_run[3],
                                                         // take_photo[4], process_photo[5],
                                                         // clear_averages[6], empty_flag[7],
                                                         // visitor_count[23:8]
);

    ptdc_pkg::cfg_t    cfg;
    ptdc_pkg::result_t res;
    ptdc_pkg::result_t res_reg;

    logic                            in_valid_reg;
    logic [ptdc_pkg::PROX_W-1:0]     prox_reg;
    logic [ptdc_pkg::WEIGHT_W-1:0]   weight_reg;
    logic                            out_valid_reg;
    logic                            out_free;
    logic                            step_en;

    // The result stage can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    // Advance the controller whenever a held tick can move into the result stage.
    assign step_en  = in_valid_reg && out_free;
    // The input stage refills whenever it is empty or handing on its tick,
    // so a waiting result stalls the input only once a tick is already held.
    assign s_tready = !in_valid_reg || out_free;

    ptdc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Input register: hold the tick fields until the controller consumes them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            prox_reg   <= s_tdata[ptdc_pkg::PROX_W-1:0];
            weight_reg <= s_tdata[ptdc_pkg::PROX_W +: ptdc_pkg::WEIGHT_W];
        end
    end

    ptdc_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .prox    (prox_reg),
        .weight  (weight_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Result register: capture the post-tick outputs, hold while stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // No result may appear without a tick having been held the cycle before.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid)) |-> $past(in_valid_reg))
        else $error("result raised without a held tick");

    // A held tick with a free result stage must be consumed.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free && !s_tvalid) |=> (!in_valid_reg && m_tvalid))
        else $error("held tick not moved on");

    // A stalled result stage with a held tick keeps the tick.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(prox_reg)
                                         && $stable(weight_reg)))
        else $error("held tick lost under back-pressure");

endmodule

// ----- rtl/ptdc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ptdc_cfg_regs
// Configuration register file: write-only, one register per mapped index.
// ----------------------------------------------------------------------------
module ptdc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ptdc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ptdc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output ptdc_pkg::cfg_t                    cfg
);

    ptdc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.proximity_threshold     <= ptdc_pkg::RST_PROX_THRESH;
            cfg_reg.food_weight_threshold   <= ptdc_pkg::RST_FOOD_THRESH;
            cfg_reg.refill_weight_threshold <= ptdc_pkg::RST_REFILL_THRESH;
            cfg_reg.cooldown_ticks          <= ptdc_pkg::RST_COOL_TICKS;
            cfg_reg.min_dispense_ticks      <= ptdc_pkg::RST_MIN_TICKS;
            cfg_reg.max_dispense_ticks      <= ptdc_pkg::RST_MAX_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ptdc_pkg::REG_PROX_THRESH: begin
                    cfg_reg.proximity_threshold <= cfg_wr_data[ptdc_pkg::PROX_W-1:0];
                end
                ptdc_pkg::REG_FOOD_THRESH: begin
                    cfg_reg.food_weight_threshold <= cfg_wr_data[ptdc_pkg::WEIGHT_W-1:0];
                end
                ptdc_pkg::REG_REFILL_THRESH: begin
                    cfg_reg.refill_weight_threshold <= cfg_wr_data[ptdc_pkg::WEIGHT_W-1:0];
                end
                ptdc_pkg::REG_COOL_TICKS: begin
                    cfg_reg.cooldown_ticks <= cfg_wr_data[ptdc_pkg::COOL_W-1:0];
                end
                ptdc_pkg::REG_MIN_TICKS: begin
                    cfg_reg.min_dispense_ticks <= cfg_wr_data[ptdc_pkg::TICKS_W-1:0];
                end
                ptdc_pkg::REG_MAX_TICKS: begin
                    cfg_reg.max_dispense_ticks <= cfg_wr_data[ptdc_pkg::TICKS_W-1:0];
                end
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/ptdc_fsm.sv -----
// ----------------------------------------------------------------------------
// ptdc_fsm
// Controller state and its one-tick update; presents the post-tick result.
// ----------------------------------------------------------------------------
module ptdc_fsm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_en,
    input  logic [ptdc_pkg::PROX_W-1:0]       prox,
    input  logic [ptdc_pkg::WEIGHT_W-1:0]     weight,
    input  ptdc_pkg::cfg_t                    cfg,
    output ptdc_pkg::result_t                 res
);

    logic [ptdc_pkg::MODE_W-1:0]    mode_reg,       mode_next;
    logic [ptdc_pkg::TICKS_W-1:0]   disp_ticks_reg, disp_ticks_next;
    logic [ptdc_pkg::COOL_W-1:0]    cool_cnt_reg,   cool_cnt_next;
    logic [ptdc_pkg::VISITOR_W-1:0] visitors_reg,   visitors_next;
    logic                           empty_reg,      empty_next;
    logic                           motor_reg,      motor_next;
    logic                           photo, process, clear;
    logic [ptdc_pkg::COOL_W-1:0]    cool_inc;

    assign cool_inc = cool_cnt_reg + 8'd1;

    always_comb begin
        mode_next       = mode_reg;
        disp_ticks_next = disp_ticks_reg;
        cool_cnt_next   = cool_cnt_reg;
        visitors_next   = visitors_reg;
        empty_next      = empty_reg;
        motor_next      = motor_reg;
        photo           = 1'b0;
        process         = 1'b0;
        clear           = 1'b0;
        unique case (mode_reg)
            ptdc_pkg::MODE_WAIT: begin
                if (prox > cfg.proximity_threshold) begin
                    mode_next = ptdc_pkg::MODE_DETECT;
                end
            end
            ptdc_pkg::MODE_DETECT: begin
                visitors_next = visitors_reg + 16'd1;
                photo         = 1'b1;
                clear         = 1'b1;
                motor_next    = 1'b1;
                mode_next     = ptdc_pkg::MODE_DISPENSE;
            end
            ptdc_pkg::MODE_DISPENSE: begin
                if (weight >= cfg.food_weight_threshold &&
                    disp_ticks_reg >= cfg.min_dispense_ticks) begin
                    motor_next      = 1'b0;
                    process         = 1'b1;
                    mode_next       = ptdc_pkg::MODE_COOL;
                    disp_ticks_next = '0;
                end else if (disp_ticks_reg >= cfg.max_dispense_ticks) begin
                    motor_next      = 1'b0;
                    process         = 1'b1;
                    mode_next       = ptdc_pkg::MODE_EMPTY;
                    disp_ticks_next = '0;
                end else begin
                    disp_ticks_next = disp_ticks_reg + 4'd1;
                end
            end
            ptdc_pkg::MODE_COOL: begin
                if (cool_inc == cfg.cooldown_ticks) begin
                    cool_cnt_next = '0;
                    mode_next     = ptdc_pkg::MODE_WAIT;
                end else begin
                    cool_cnt_next = cool_inc;
                end
            end
            ptdc_pkg::MODE_EMPTY: begin
                empty_next = 1'b1;
                if (weight > cfg.refill_weight_threshold) begin
                    empty_next = 1'b0;
                    mode_next  = ptdc_pkg::MODE_WAIT;
                end
            end
            default: begin
                mode_next = ptdc_pkg::MODE_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ptdc_pkg::MODE_WAIT;
            disp_ticks_reg <= '0;
            cool_cnt_reg   <= '0;
            visitors_reg   <= '0;
            empty_reg      <= 1'b0;
            motor_reg      <= 1'b0;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            disp_ticks_reg <= disp_ticks_next;
            cool_cnt_reg   <= cool_cnt_next;
            visitors_reg   <= visitors_next;
            empty_reg      <= empty_next;
            motor_reg      <= motor_next;
        end
    end

    assign res.mode_code      = mode_next;
    assign res.motor_run      = motor_next;
    assign res.take_photo     = photo;
    assign res.process_photo  = process;
    assign res.clear_averages = clear;
    assign res.empty_flag     = empty_next;
    assign res.visitor_count  = visitors_next;

    // The motor runs exactly while dispensing.
    a_motor_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        motor_reg == (mode_reg == ptdc_pkg::MODE_DISPENSE))
        else $error("motor state disagrees with mode");

    // The empty mark lives only in the out-of-food mode.
    a_empty_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (mode_reg == ptdc_pkg::MODE_EMPTY))
        else $error("empty mark outside out-of-food mode");

    // Tick counters stay cleared outside their own modes.
    a_disp_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (disp_ticks_reg != '0) |-> (mode_reg == ptdc_pkg::MODE_DISPENSE))
        else $error("dispense tick count left over");

    a_cool_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cool_cnt_reg != '0) |-> (mode_reg == ptdc_pkg::MODE_COOL))
        else $error("cooldown count left over");

    // A visitor is counted on every detection tick and at no other time.
    a_visitor_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && mode_reg != ptdc_pkg::MODE_DETECT) |=> $stable(visitors_reg))
        else $error("visitor count moved outside detection");

endmodule

// ----- tb/dispense_result_checker.sv -----
// ----------------------------------------------------------------------------
// dispense_result_checker
// Watches the configuration port and both streams of the dispense controller,
// predicts one result per accepted tick and compares it field by field with
// what the block hands out.
// ----------------------------------------------------------------------------
module dispense_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ptdc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ptdc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ptdc_pkg::S_TDATA_W-1:0]  s_tdata,   // proximity_level, tray_weight,
                                                       // zero pad
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ptdc_pkg::M_TDATA_W-1:0]  m_tdata,   // mode_code, motor_run, take_photo,
                                                       // process_photo, clear_averages,
                                                       // empty_flag, visitor_count
    output int                              fail_count,
    output int                              results_due
);

    localparam int MAX_REPORTS = 40;

    ptdc_pkg::cfg_t                 shadow_cfg;
    logic [ptdc_pkg::MODE_W-1:0]    ctl_mode;
    logic [ptdc_pkg::TICKS_W-1:0]   disp_ticks;
    logic [ptdc_pkg::COOL_W-1:0]    cool_count;
    logic [ptdc_pkg::VISITOR_W-1:0] visitor_total;
    logic                           empty_mark;
    logic                           motor_on;
    ptdc_pkg::result_t              pending_results[$];
    int                             reports;

    // Advance the controller by one tick and return the result it gives.
    function automatic ptdc_pkg::result_t step_controller(
        input logic [ptdc_pkg::PROX_W-1:0]   prox,
        input logic [ptdc_pkg::WEIGHT_W-1:0] weight);
        ptdc_pkg::result_t r;
        r = '0;
        case (ctl_mode)
            ptdc_pkg::MODE_WAIT: begin
                if (prox > shadow_cfg.proximity_threshold)
                    ctl_mode = ptdc_pkg::MODE_DETECT;
            end
            ptdc_pkg::MODE_DETECT: begin
                visitor_total    = visitor_total + 1'b1;
                r.take_photo     = 1'b1;
                r.clear_averages = 1'b1;
                motor_on         = 1'b1;
                ctl_mode         = ptdc_pkg::MODE_DISPENSE;
            end
            ptdc_pkg::MODE_DISPENSE: begin
                // weight decides first, then the tick ceiling
                if (weight >= shadow_cfg.food_weight_threshold &&
                    disp_ticks >= shadow_cfg.min_dispense_ticks) begin
                    motor_on        = 1'b0;
                    r.process_photo = 1'b1;
                    ctl_mode        = ptdc_pkg::MODE_COOL;
                    disp_ticks      = '0;
                end else if (disp_ticks >= shadow_cfg.max_dispense_ticks) begin
                    motor_on        = 1'b0;
                    r.process_photo = 1'b1;
                    ctl_mode        = ptdc_pkg::MODE_EMPTY;
                    disp_ticks      = '0;
                end else begin
                    disp_ticks = disp_ticks + 1'b1;
                end
            end
            ptdc_pkg::MODE_COOL: begin
                cool_count = cool_count + 1'b1;
                if (cool_count == shadow_cfg.cooldown_ticks) begin
                    cool_count = '0;
                    ctl_mode   = ptdc_pkg::MODE_WAIT;
                end
            end
            ptdc_pkg::MODE_EMPTY: begin
                empty_mark = 1'b1;
                if (weight > shadow_cfg.refill_weight_threshold) begin
                    empty_mark = 1'b0;
                    ctl_mode   = ptdc_pkg::MODE_WAIT;
                end
            end
            default: ctl_mode = ptdc_pkg::MODE_WAIT;
        endcase
        r.mode_code     = ctl_mode;
        r.motor_run     = motor_on;
        r.empty_flag    = empty_mark;
        r.visitor_count = visitor_total;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            reports++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        ptdc_pkg::result_t want;
        ptdc_pkg::result_t got;
        if (!aresetn) begin
            shadow_cfg    = '{ptdc_pkg::RST_PROX_THRESH, ptdc_pkg::RST_FOOD_THRESH,
                              ptdc_pkg::RST_REFILL_THRESH, ptdc_pkg::RST_COOL_TICKS,
                              ptdc_pkg::RST_MIN_TICKS, ptdc_pkg::RST_MAX_TICKS};
            ctl_mode      = ptdc_pkg::MODE_WAIT;
            disp_ticks    = '0;
            cool_count    = '0;
            visitor_total = '0;
            empty_mark    = 1'b0;
            motor_on      = 1'b0;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    ptdc_pkg::REG_PROX_THRESH:
                        shadow_cfg.proximity_threshold = cfg_wr_data[ptdc_pkg::PROX_W-1:0];
                    ptdc_pkg::REG_FOOD_THRESH:
                        shadow_cfg.food_weight_threshold = cfg_wr_data;
                    ptdc_pkg::REG_REFILL_THRESH:
                        shadow_cfg.refill_weight_threshold = cfg_wr_data;
                    ptdc_pkg::REG_COOL_TICKS:
                        shadow_cfg.cooldown_ticks = cfg_wr_data[ptdc_pkg::COOL_W-1:0];
                    ptdc_pkg::REG_MIN_TICKS:
                        shadow_cfg.min_dispense_ticks = cfg_wr_data[ptdc_pkg::TICKS_W-1:0];
                    ptdc_pkg::REG_MAX_TICKS:
                        shadow_cfg.max_dispense_ticks = cfg_wr_data[ptdc_pkg::TICKS_W-1:0];
                    default: ;     // unmapped indexes are dropped
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = ptdc_pkg::result_t'(m_tdata);
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (reports < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got %h",
                                 $time, m_tdata);
                    reports++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("mode_code", 32'(want.mode_code), 32'(got.mode_code));
                    check_field("motor_run", 32'(want.motor_run), 32'(got.motor_run));
                    check_field("take_photo", 32'(want.take_photo), 32'(got.take_photo));
                    check_field("process_photo", 32'(want.process_photo),
                                32'(got.process_photo));
                    check_field("clear_averages", 32'(want.clear_averages),
                                32'(got.clear_averages));
                    check_field("empty_flag", 32'(want.empty_flag), 32'(got.empty_flag));
                    check_field("visitor_count", 32'(want.visitor_count),
                                32'(got.visitor_count));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(
                    step_controller(s_tdata[ptdc_pkg::PROX_W-1:0],
                                    s_tdata[ptdc_pkg::PROX_W +: ptdc_pkg::WEIGHT_W]));
        end
        results_due = pending_results.size();
    end

endmodule

// ----- tb/tb_presence_triggered_dispense_controller.sv -----
// ----------------------------------------------------------------------------
// tb_presence_triggered_dispense_controller
// Drives ticks into the dispense controller under a sequence of register
// settings, with random gaps on both streams, and leaves all prediction and
// comparison to the result checker beside the block. Gives the verdict.
// ----------------------------------------------------------------------------
module tb_presence_triggered_dispense_controller;

    localparam int DUT_LATENCY   = 2;
    localparam int SETTLE_CYCLES = DUT_LATENCY + 2;
    localparam int QUIET_LIMIT   = 4000;     // cycles with no transaction at all
    localparam int LONG_HOLD     = 400;      // receiver hold-off for the back-pressure test
    localparam int PROX_MAX      = (1 << ptdc_pkg::PROX_W) - 1;
    localparam int WEIGHT_MAX    = (1 << ptdc_pkg::WEIGHT_W) - 1;
    localparam int BURST_TICKS   = 120;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 150;

    // Indexes past the register map: writes there must leave everything alone
    localparam logic [ptdc_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [ptdc_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [ptdc_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [ptdc_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [ptdc_pkg::S_TDATA_W-1:0]  s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [ptdc_pkg::M_TDATA_W-1:0]  m_tdata;

    int             fail_count;
    int             results_due;
    int             quiet_cycles = 0;
    ptdc_pkg::cfg_t cur_cfg;       // settings last written, used to aim the stimulus
    bit             tx_idle_on   = 1'b1;
    bit             rx_idle_on   = 1'b1;
    bit             rx_long_hold = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    presence_triggered_dispense_controller DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    dispense_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // Watchdog: abandon the run once nothing has moved on any port for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                           : int'($urandom_range(1, 3));
    endfunction

    // Proximity aimed at the detection threshold: on it, either side of it,
    // well above, well below, and sometimes anywhere in the field's range.
    function automatic logic [ptdc_pkg::PROX_W-1:0] pick_prox();
        int thr;
        int v;
        thr = int'(cur_cfg.proximity_threshold);
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, PROX_MAX);
            2:       v = thr;
            3:       v = thr + 1;
            4:       v = thr - 1;
            5, 6:    v = $urandom_range(thr + 1, PROX_MAX);
            default: v = $urandom_range(0, thr);
        endcase
        if (v < 0)        v = 0;
        if (v > PROX_MAX) v = PROX_MAX;
        return ptdc_pkg::PROX_W'(v);
    endfunction

    // Weight aimed at the food and refill thresholds in the same way.
    function automatic logic [ptdc_pkg::WEIGHT_W-1:0] pick_weight();
        int food;
        int refill;
        int v;
        food   = int'(cur_cfg.food_weight_threshold);
        refill = int'(cur_cfg.refill_weight_threshold);
        case ($urandom_range(0, 11))
            0, 1:    v = $urandom_range(0, WEIGHT_MAX);
            2:       v = food - 1;
            3:       v = food;
            4:       v = food + 1;
            5:       v = refill;
            6:       v = refill + 1;
            7, 8:    v = $urandom_range(0, food);
            9:       v = $urandom_range(food, refill);
            default: v = $urandom_range(refill, WEIGHT_MAX);
        endcase
        if (v < 0)          v = 0;
        if (v > WEIGHT_MAX) v = WEIGHT_MAX;
        return ptdc_pkg::WEIGHT_W'(v);
    endfunction

    // Random settings: mostly moderate thresholds and short cooldowns, with an
    // occasional zero or very long cooldown and minimum above maximum.
    function automatic ptdc_pkg::cfg_t random_config();
        ptdc_pkg::cfg_t c;
        int             food;
        int             refill;
        int             lo;
        int             hi;
        if ($urandom_range(0, 3) == 0)
            c.proximity_threshold = ptdc_pkg::PROX_W'($urandom_range(0, PROX_MAX));
        else
            c.proximity_threshold = ptdc_pkg::PROX_W'($urandom_range(500, 3500));
        food = ($urandom_range(0, 4) == 0) ? $urandom_range(0, WEIGHT_MAX)
                                           : $urandom_range(1000, 60000);
        refill = ($urandom_range(0, 4) == 0) ? $urandom_range(0, WEIGHT_MAX)
                                             : food + $urandom_range(0, 100000);
        if (refill > WEIGHT_MAX) refill = WEIGHT_MAX;
        c.food_weight_threshold   = ptdc_pkg::WEIGHT_W'(food);
        c.refill_weight_threshold = ptdc_pkg::WEIGHT_W'(refill);
        case ($urandom_range(0, 9))
            0:       c.cooldown_ticks = '0;
            1:       c.cooldown_ticks = ptdc_pkg::COOL_W'($urandom_range(13, 255));
            default: c.cooldown_ticks = ptdc_pkg::COOL_W'($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 2) == 0) begin
            lo = $urandom_range(0, 15);
            hi = $urandom_range(0, 15);
        end else begin
            lo = $urandom_range(0, 4);
            hi = lo + $urandom_range(0, 6);
        end
        c.min_dispense_ticks = ptdc_pkg::TICKS_W'(lo);
        c.max_dispense_ticks = ptdc_pkg::TICKS_W'((hi > 15) ? 15 : hi);
        return c;
    endfunction

    // Offer one tick, after a random gap when the sender idles, and hold it
    // until the block takes it. Returns at the falling edge after the transaction.
    task automatic send_tick(input logic [ptdc_pkg::PROX_W-1:0]   prox,
                             input logic [ptdc_pkg::WEIGHT_W-1:0] weight);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ptdc_pkg::S_TDATA_W - ptdc_pkg::PROX_W - ptdc_pkg::WEIGHT_W){1'b0}},
                     weight, prox};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering, wait until every predicted result has been taken, then
    // give the pipeline time to settle.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [ptdc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [ptdc_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
    endtask

    // Write every register, plus both unmapped indexes, back to back.
    task automatic load_config(input ptdc_pkg::cfg_t c);
        write_reg(ptdc_pkg::REG_PROX_THRESH,
                  ptdc_pkg::CFG_DATA_W'(c.proximity_threshold));
        write_reg(ptdc_pkg::REG_FOOD_THRESH,   c.food_weight_threshold);
        write_reg(ptdc_pkg::REG_REFILL_THRESH, c.refill_weight_threshold);
        write_reg(ptdc_pkg::REG_COOL_TICKS,
                  ptdc_pkg::CFG_DATA_W'(c.cooldown_ticks));
        write_reg(ptdc_pkg::REG_MIN_TICKS,
                  ptdc_pkg::CFG_DATA_W'(c.min_dispense_ticks));
        write_reg(ptdc_pkg::REG_MAX_TICKS,
                  ptdc_pkg::CFG_DATA_W'(c.max_dispense_ticks));
        write_reg(REG_SPARE_A, ptdc_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, '1);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic run_random_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_tick(pick_prox(), pick_weight());
    endtask

    // Receiver: take results with random stalls, and on request hold off for
    // one long stretch counted here, so the block fills and stalls its input.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                hold_left    = LONG_HOLD - 1;
                m_tready    <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                hold_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        cur_cfg = '{ptdc_pkg::RST_PROX_THRESH, ptdc_pkg::RST_FOOD_THRESH,
                    ptdc_pkg::RST_REFILL_THRESH, ptdc_pkg::RST_COOL_TICKS,
                    ptdc_pkg::RST_MIN_TICKS, ptdc_pkg::RST_MAX_TICKS};

        // Directed walk through every mode under the reset settings.
        // Proximity exactly on the threshold must not trigger; one above must.
        send_tick('0, '0);
        send_tick(ptdc_pkg::RST_PROX_THRESH, '1);
        send_tick(ptdc_pkg::RST_PROX_THRESH + 1'b1, '0);
        // Detection tick: visitor counted, photo and average-clear pulsed, motor on
        send_tick('0, '0);
        // Heavy tray before the minimum tick count must not end dispensing
        send_tick('1, '1);
        send_tick('1, '1);
        send_tick('0, ptdc_pkg::WEIGHT_W'(ptdc_pkg::RST_FOOD_THRESH - 1'b1));
        // Weight exactly on the food threshold ends it normally
        send_tick('0, ptdc_pkg::RST_FOOD_THRESH);

        // Shorten the cooldown to one tick so the walk can go on
        pause_until_drained();
        write_reg(ptdc_pkg::REG_COOL_TICKS, ptdc_pkg::CFG_DATA_W'(1));
        cfg_wr_en <= 1'b0;
        cur_cfg.cooldown_ticks = 8'd1;
        send_tick('1, '0);
        send_tick('1, '0);
        send_tick('0, '0);
        // Empty tray right up to the tick ceiling: out of food
        for (int i = 0; i <= int'(ptdc_pkg::RST_MAX_TICKS); i++)
            send_tick('0, '0);
        // Flag rises on the first tick in out-of-food; weight on the refill
        // threshold keeps it, one above clears it
        send_tick('0, ptdc_pkg::RST_REFILL_THRESH);
        send_tick('0, ptdc_pkg::RST_REFILL_THRESH + 1'b1);

        // Every register at its maximum: detection is impossible
        pause_until_drained();
        load_config('{'1, '1, '1, '1, '1, '1});
        run_random_ticks(40);

        // Just below the top: only the extreme readings move the controller
        pause_until_drained();
        load_config('{ptdc_pkg::PROX_W'(PROX_MAX - 1), '1,
                      ptdc_pkg::WEIGHT_W'(WEIGHT_MAX - 1), '1, '1, '1});
        run_random_ticks(200);

        // Zero cooldown: the counter has to wrap round before waiting again
        pause_until_drained();
        load_config('{12'd2000, 18'd20000, 18'd150000, 8'd0, 4'd2, 4'd6});
        run_random_ticks(200);

        // Lowest settings give a four-tick visit; run a stretch of visits
        // back to back without any idling on either side
        pause_until_drained();
        load_config('{'0, '0, '0, 8'd1, '0, '0});
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int i = 0; i < BURST_TICKS; i++)
            send_tick(ptdc_pkg::PROX_W'($urandom_range(1, PROX_MAX)),
                      ptdc_pkg::WEIGHT_W'($urandom_range(1, WEIGHT_MAX)));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random_ticks(60);

        // Random settings; phase 1 keeps the sender busy through the long
        // receiver hold-off, phase 3 pauses halfway until all results are in
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pause_until_drained();
            load_config(random_config());
            tx_idle_on = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 1)
                rx_long_hold = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 3 && i == PHASE_ITEMS / 2)
                    pause_until_drained();
                send_tick(pick_prox(), pick_weight());
            end
        end

        // Drain, then linger long enough to catch any stray extra result
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (4 * SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && results_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ptdc_pkg.sv
rtl/ptdc_cfg_regs.sv
rtl/ptdc_fsm.sv
rtl/presence_triggered_dispense_controller.sv
tb/dispense_result_checker.sv
tb/tb_presence_triggered_dispense_controller.sv
